// ===== rtl/tlc_pkg.sv =====
`default_nettype none

package tlc_pkg;

    localparam logic [31:0] LIFETIME_RESET = 32'd300;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] now_seconds;
        logic [63:0] host_key;
        logic [31:0] insert_address;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_address;
        logic [4:0]  valid_entries;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } rsp_t;

    // Transaction record handed from cell to cell during a scan.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now;
        logic [63:0] key;
        logic [31:0] addr;
        logic        hit;
        logic [31:0] found_addr;
        logic        free_found;
        logic [31:0] old_stamp;
    } wave_t;

    // Entry contents broadcast at insert write-back.
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] addr;
        logic [31:0] stamp;
        logic [31:0] life;
    } wr_t;

endpackage

`default_nettype wire

// ===== rtl/tlc_cell.sv =====
`default_nettype none

module tlc_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_act,
    input  tlc_pkg::wave_t      in_wave,
    input  wire  [CNT_W-1:0]    in_cnt,
    input  wire  [IDX_W-1:0]    in_free_idx,
    input  wire  [IDX_W-1:0]    in_old_idx,
    input  wire                 wr_sel,
    input  tlc_pkg::wr_t        wr_data,
    output logic                out_act,
    output tlc_pkg::wave_t      out_wave,
    output logic [CNT_W-1:0]    out_cnt,
    output logic [IDX_W-1:0]    out_free_idx,
    output logic [IDX_W-1:0]    out_old_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic           valid_reg, valid_next;
    logic [63:0]    key_reg;
    logic [31:0]    addr_reg;
    logic [31:0]    stamp_reg;
    logic [31:0]    life_reg;

    logic                out_act_reg;
    tlc_pkg::wave_t      wave_reg, wave_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    old_idx_reg, old_idx_next;

    logic           matched;
    logic           live;
    logic           post_valid;

    assign matched = valid_reg && (key_reg == in_wave.key);
    assign live    = (in_wave.now - stamp_reg) < life_reg;

    always_comb
    begin
        wave_next     = in_wave;
        free_idx_next = in_free_idx;
        old_idx_next  = in_old_idx;
        post_valid    = valid_reg;
        case (in_wave.cmd)
            tlc_pkg::CMD_LOOKUP:
            begin
                if (!in_wave.hit && matched)
                begin
                    if (live)
                    begin
                        wave_next.hit        = 1'b1;
                        wave_next.found_addr = addr_reg;
                    end
                    else
                    begin
                        post_valid = 1'b0;
                    end
                end
            end
            tlc_pkg::CMD_INSERT:
            begin
                if (!valid_reg && !in_wave.free_found)
                begin
                    wave_next.free_found = 1'b1;
                    free_idx_next        = MY_IDX;
                end
                // cell 0 seeds the oldest search
                if (valid_reg && (INDEX == 0 || stamp_reg < in_wave.old_stamp))
                begin
                    wave_next.old_stamp = stamp_reg;
                    old_idx_next        = MY_IDX;
                end
            end
            tlc_pkg::CMD_CLEAR:
            begin
                post_valid = 1'b0;
            end
            default:
            begin
                post_valid = valid_reg;
            end
        endcase
        cnt_next = in_cnt + CNT_W'(post_valid);
    end

    always_comb
    begin
        if (wr_sel)
            valid_next = 1'b1;
        else if (in_act)
            valid_next = post_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            out_act_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            out_act_reg <= in_act;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            key_reg   <= wr_data.key;
            addr_reg  <= wr_data.addr;
            stamp_reg <= wr_data.stamp;
            life_reg  <= wr_data.life;
        end
        if (in_act)
        begin
            wave_reg     <= wave_next;
            cnt_reg      <= cnt_next;
            free_idx_reg <= free_idx_next;
            old_idx_reg  <= old_idx_next;
        end
    end

    assign out_act      = out_act_reg;
    assign out_wave     = wave_reg;
    assign out_cnt      = cnt_reg;
    assign out_free_idx = free_idx_reg;
    assign out_old_idx  = old_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/ttl_lookup_cache_core.sv =====
// Fully associative host-key to IPv4 cache with a lifetime on every entry.
//
// Command channel: a transaction (req) is taken at a clock edge where start
// is high and busy is low. busy stays high until the result is produced.
// Result channel: done pulses for one cycle with rsp; there is no back
// pressure, the receiver must take it in that cycle.
// Config: lifetime_we/lifetime_wdata write the lifetime given to new entries
// (reset value 300). Write it only while the block is idle.
//
// Every transaction flows through a chain of ENTRIES cells, registered in
// each cell in turn starting at the accepting edge, then through write-back
// and counter update, which register done and rsp together. busy drops in
// the done cycle, so a new command can be taken at the edge that ends it;
// only one transaction is in flight at a time, and the length of the cell
// chain sets how often a transaction can start.
//
// Reset empties the cache and zeroes the hit and miss counters. Entry
// contents are not cleared; only the valid marks are.
`default_nettype none

module ttl_lookup_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  tlc_pkg::req_t       req,
    input  wire                 lifetime_we,
    input  wire  [31:0]         lifetime_wdata,
    output logic                done,
    output tlc_pkg::rsp_t       rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [ENTRIES:0]    act;
    tlc_pkg::wave_t      wave     [0:ENTRIES];
    logic [CNT_W-1:0]    cnt      [0:ENTRIES];
    logic [IDX_W-1:0]    free_idx [0:ENTRIES];
    logic [IDX_W-1:0]    old_idx  [0:ENTRIES];
    logic [ENTRIES-1:0]  wr_sel;
    tlc_pkg::wr_t        wr_data;

    logic           busy_reg, busy_next;
    logic           done_reg;
    tlc_pkg::rsp_t  rsp_reg, rsp_next;
    logic [31:0]    hit_cnt_reg, hit_cnt_next;
    logic [31:0]    miss_cnt_reg, miss_cnt_next;
    logic [31:0]    lifetime_reg;

    logic               accept;
    logic               fin;
    logic               ins;
    logic [IDX_W-1:0]   slot;
    logic [CNT_W-1:0]   final_cnt;
    tlc_pkg::wave_t     last;

    assign accept = start && !busy_reg;

    // head of the chain: cmd, now, key, addr, then cleared scan fields
    assign act[0]      = accept;
    assign wave[0]     = {req.command, req.now_seconds, req.host_key, req.insert_address,
                          1'b0, 32'd0, 1'b0, 32'd0};
    assign cnt[0]      = '0;
    assign free_idx[0] = '0;
    assign old_idx[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tlc_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_act       (act[i]),
            .in_wave      (wave[i]),
            .in_cnt       (cnt[i]),
            .in_free_idx  (free_idx[i]),
            .in_old_idx   (old_idx[i]),
            .wr_sel       (wr_sel[i]),
            .wr_data      (wr_data),
            .out_act      (act[i+1]),
            .out_wave     (wave[i+1]),
            .out_cnt      (cnt[i+1]),
            .out_free_idx (free_idx[i+1]),
            .out_old_idx  (old_idx[i+1])
        );

        assign wr_sel[i] = fin && ins && (slot == IDX_W'(i));
    end

    // write-back stage at the end of the chain
    assign fin  = act[ENTRIES];
    assign last = wave[ENTRIES];
    assign ins  = (last.cmd == tlc_pkg::CMD_INSERT);
    assign slot = last.free_found ? free_idx[ENTRIES] : old_idx[ENTRIES];

    always_comb
    begin
        wr_data.key   = last.key;
        wr_data.addr  = last.addr;
        wr_data.stamp = last.now;
        wr_data.life  = lifetime_reg;
    end

    always_comb
    begin
        final_cnt     = cnt[ENTRIES] + CNT_W'(ins && last.free_found);
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (last.cmd == tlc_pkg::CMD_LOOKUP)
        begin
            if (last.hit)
                hit_cnt_next = hit_cnt_reg + 32'd1;
            else
                miss_cnt_next = miss_cnt_reg + 32'd1;
        end
        rsp_next.hit           = (last.cmd == tlc_pkg::CMD_LOOKUP) && last.hit;
        rsp_next.found_address = rsp_next.hit ? last.found_addr : 32'd0;
        rsp_next.valid_entries = 5'(final_cnt);
        rsp_next.hit_total     = hit_cnt_next;
        rsp_next.miss_total    = miss_cnt_next;
    end

    always_comb
    begin
        if (accept)
            busy_next = 1'b1;
        else if (fin)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            hit_cnt_reg  <= 32'd0;
            miss_cnt_reg <= 32'd0;
            lifetime_reg <= tlc_pkg::LIFETIME_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= fin;
            if (fin)
            begin
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end
            if (lifetime_we)
                lifetime_reg <= lifetime_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
            rsp_reg <= rsp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // only one transaction may be in the chain at a time
    a_single_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act[ENTRIES:1]))
        else $error("more than one transaction in the cell chain");

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a command");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high while result is presented");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (rsp.found_address == $past(last.found_addr)))
        else $error("hit result address mismatch");

endmodule

`default_nettype wire
